// File: rtl/pn2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn2d_pkg: shared types and constants of the 2D gradient noise block
// Field widths, item kinds and the arithmetic widths of the datapath.
// ----------------------------------------------------------------------------
package pn2d_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned NOISE_W = 18;
  localparam int unsigned DEPTH   = 256;

  // Datapath widths.
  localparam int unsigned FF_W  = 32;  // f^2
  localparam int unsigned FFF_W = 48;  // f^3
  localparam int unsigned P_W   = 37;  // 6f^2 - 15f*2^16 + 10*2^32
  localparam int unsigned P16_W = 21;
  localparam int unsigned C24_W = 25;
  localparam int unsigned UR_W  = 46;  // c24 * p16
  localparam int unsigned T_W   = 17;  // fade weight, 0..65536
  localparam int unsigned D_W   = 18;  // signed corner distance
  localparam int unsigned G_W   = 20;  // gradient value
  localparam int unsigned DF_W  = 21;  // gradient difference
  localparam int unsigned PX_W  = 39;  // weight times difference
  localparam int unsigned X_W   = 21;  // first blend
  localparam int unsigned DX_W  = 22;
  localparam int unsigned PY_W  = 40;
  localparam int unsigned Y_W   = 21;

  localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sd131071;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sd131072;

  typedef enum logic {
    KIND_EVAL  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  // Gradient of a corner: bit 1 of the hash swaps the axes and negates the
  // doubled term, bit 0 negates the single term.
  function automatic logic signed [G_W-1:0] grad(input logic [1:0] h,
                                                 input logic signed [D_W-1:0] gx,
                                                 input logic signed [D_W-1:0] gy);
    logic signed [G_W-1:0] u;
    logic signed [G_W-1:0] v;
    logic signed [G_W-1:0] a;
    logic signed [G_W-1:0] b;
    u = h[1] ? G_W'(gy) : G_W'(gx);
    v = h[1] ? G_W'(gx) : G_W'(gy);
    a = h[0] ? -u : u;
    b = h[1] ? -(v <<< 1) : (v <<< 1);
    return a + b;
  endfunction

endpackage

// File: rtl/pn2d_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn2d_in_if: input channel of the noise block
// Carries a point to evaluate or one permutation table write.
// ----------------------------------------------------------------------------
interface pn2d_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [pn2d_pkg::COORD_W-1:0]      x_coord;
  logic [pn2d_pkg::COORD_W-1:0]      y_coord;
  logic [pn2d_pkg::IDX_W-1:0]        table_index;
  logic [pn2d_pkg::VAL_W-1:0]        table_value;

  modport source (output valid, kind, x_coord, y_coord, table_index, table_value,
                  input ready);
  modport sink (input valid, kind, x_coord, y_coord, table_index, table_value,
                output ready);
endinterface

// File: rtl/pn2d_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn2d_out_if: result channel of the noise block
// Carries one noise sample per evaluated point.
// ----------------------------------------------------------------------------
interface pn2d_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pn2d_pkg::NOISE_W-1:0]     noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// File: rtl/perlin_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_2d: 2D gradient noise with a loadable permutation table
//
//   channel | dir | transfer carries
//   in_i    | in  | kind, x_coord, y_coord, table_index, table_value
//   out_o   | out | noise_value (only for evaluate items)
//
// One item per cycle is taken unless every stage is full and the result waits.
// The rate is set by the table: it is held in three copies with two read
// ports each, giving the two first-level and four second-level hash reads.
// A table write lands at its own transfer edge; no clearing pass after reset.
// Each stage holds only when the one after it is full and holding, so a
// waiting result stalls only the items behind it and bubbles close up.
// ----------------------------------------------------------------------------
module perlin_noise_2d #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pn2d_in_if.sink    in_i,
  pn2d_out_if.source out_o
);

  localparam int unsigned NSTG  = 9;
  localparam int unsigned SUM_W = $clog2(2 * TABLE_SIZE);
  localparam int unsigned A_W   = pn2d_pkg::IDX_W;

  // Index modulo the table size; sums always stay below twice the size.
  function automatic logic [SUM_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    return (s >= SUM_W'(TABLE_SIZE)) ? s - SUM_W'(TABLE_SIZE) : s;
  endfunction

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  logic acc, wr_en, ev_en;
  assign in_i.ready = en[0];
  assign acc   = in_i.valid && en[0];
  assign wr_en = acc && (in_i.kind == pn2d_pkg::KIND_WRITE);
  assign ev_en = acc && (in_i.kind == pn2d_pkg::KIND_EVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= ev_en;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage 1: first-level hash reads, f^2 ----------------
  logic [pn2d_pkg::FRAC_W-1:0] fx, fy;
  logic [A_W-1:0] ix, iy;
  logic [SUM_W-1:0] hb_idx;
  assign ix = in_i.x_coord[pn2d_pkg::COORD_W-1 -: A_W];
  assign iy = in_i.y_coord[pn2d_pkg::COORD_W-1 -: A_W];
  assign fx = in_i.x_coord[pn2d_pkg::FRAC_W-1:0];
  assign fy = in_i.y_coord[pn2d_pkg::FRAC_W-1:0];
  assign hb_idx = wrap_idx(SUM_W'(ix) + SUM_W'(1));

  logic [A_W-1:0] mem0 [pn2d_pkg::DEPTH];
  logic [A_W-1:0] mem1 [pn2d_pkg::DEPTH];
  logic [A_W-1:0] mem2 [pn2d_pkg::DEPTH];

  logic [pn2d_pkg::FRAC_W-1:0] fx1_q, fy1_q;
  logic [A_W-1:0] iy1_q, ha1_q, hb1_q;
  logic hb_hi1_q;
  logic [pn2d_pkg::FF_W-1:0] ffx1_q, ffy1_q;

  // A write only happens when stage 1 can load, so any evaluate still
  // waiting for its second-level reads moves on at the same edge and
  // reads the old contents, as ordering requires.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem0[in_i.table_index] <= in_i.table_value;
      mem1[in_i.table_index] <= in_i.table_value;
      mem2[in_i.table_index] <= in_i.table_value;
    end
    if (en[0]) begin
      ha1_q    <= mem0[ix];
      hb1_q    <= mem0[hb_idx[A_W-1:0]];
      hb_hi1_q <= |hb_idx[SUM_W-1:A_W];
      fx1_q    <= fx;
      fy1_q    <= fy;
      iy1_q    <= iy;
      ffx1_q   <= pn2d_pkg::FF_W'(fx) * pn2d_pkg::FF_W'(fx);
      ffy1_q   <= pn2d_pkg::FF_W'(fy) * pn2d_pkg::FF_W'(fy);
    end
  end

  // ---------------- stage 2: corner hash reads, f^3, p16 ----------------
  logic [A_W-1:0] hb_eff;
  logic [SUM_W-1:0] aa_idx, ab_idx, ba_idx, bb_idx;
  assign hb_eff = hb_hi1_q ? '0 : hb1_q;
  assign aa_idx = wrap_idx(SUM_W'(ha1_q) + SUM_W'(iy1_q));
  assign ab_idx = wrap_idx(SUM_W'(ha1_q) + SUM_W'(iy1_q) + SUM_W'(1));
  assign ba_idx = wrap_idx(SUM_W'(hb_eff) + SUM_W'(iy1_q));
  assign bb_idx = wrap_idx(SUM_W'(hb_eff) + SUM_W'(iy1_q) + SUM_W'(1));

  function automatic logic [pn2d_pkg::P16_W-1:0] p16_of(
      input logic [pn2d_pkg::FF_W-1:0] ff, input logic [pn2d_pkg::FRAC_W-1:0] f);
    logic [pn2d_pkg::P_W:0] p;
    p = (pn2d_pkg::P_W+1)'(ff) * (pn2d_pkg::P_W+1)'(6)
        + ((pn2d_pkg::P_W+1)'(10) << 32)
        - ((pn2d_pkg::P_W+1)'(f) << 20) + ((pn2d_pkg::P_W+1)'(f) << 16)
        + (pn2d_pkg::P_W+1)'(32768);
    return p[16 +: pn2d_pkg::P16_W];
  endfunction

  logic [A_W-1:0] aa2_q, ab2_q, ba2_q, bb2_q;
  logic aa_hi2_q, ab_hi2_q, ba_hi2_q, bb_hi2_q;
  logic [pn2d_pkg::FRAC_W-1:0] fx2_q, fy2_q;
  logic [pn2d_pkg::FFF_W-1:0] fffx2_q, fffy2_q;
  logic [pn2d_pkg::P16_W-1:0] p16x2_q, p16y2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      aa2_q    <= mem1[aa_idx[A_W-1:0]];
      ab2_q    <= mem1[ab_idx[A_W-1:0]];
      ba2_q    <= mem2[ba_idx[A_W-1:0]];
      bb2_q    <= mem2[bb_idx[A_W-1:0]];
      aa_hi2_q <= |aa_idx[SUM_W-1:A_W];
      ab_hi2_q <= |ab_idx[SUM_W-1:A_W];
      ba_hi2_q <= |ba_idx[SUM_W-1:A_W];
      bb_hi2_q <= |bb_idx[SUM_W-1:A_W];
      fx2_q    <= fx1_q;
      fy2_q    <= fy1_q;
      fffx2_q  <= pn2d_pkg::FFF_W'(ffx1_q) * pn2d_pkg::FFF_W'(fx1_q);
      fffy2_q  <= pn2d_pkg::FFF_W'(ffy1_q) * pn2d_pkg::FFF_W'(fy1_q);
      p16x2_q  <= p16_of(ffx1_q, fx1_q);
      p16y2_q  <= p16_of(ffy1_q, fy1_q);
    end
  end

  // ---------------- stage 3: gradients, c24 ----------------
  logic signed [pn2d_pkg::D_W-1:0] gx0, gx1, gy0, gy1;
  logic [1:0] h_aa, h_ab, h_ba, h_bb;
  logic [pn2d_pkg::FFF_W:0] c24x_s, c24y_s;
  assign gx0 = $signed({2'b00, fx2_q});
  assign gy0 = $signed({2'b00, fy2_q});
  assign gx1 = gx0 - pn2d_pkg::D_W'(65536);
  assign gy1 = gy0 - pn2d_pkg::D_W'(65536);
  assign h_aa = aa_hi2_q ? 2'b00 : aa2_q[1:0];
  assign h_ab = ab_hi2_q ? 2'b00 : ab2_q[1:0];
  assign h_ba = ba_hi2_q ? 2'b00 : ba2_q[1:0];
  assign h_bb = bb_hi2_q ? 2'b00 : bb2_q[1:0];
  assign c24x_s = (pn2d_pkg::FFF_W+1)'(fffx2_q) + (pn2d_pkg::FFF_W+1)'(1 << 23);
  assign c24y_s = (pn2d_pkg::FFF_W+1)'(fffy2_q) + (pn2d_pkg::FFF_W+1)'(1 << 23);

  logic signed [pn2d_pkg::G_W-1:0] gaa3_q, gab3_q, gba3_q, gbb3_q;
  logic [pn2d_pkg::C24_W-1:0] c24x3_q, c24y3_q;
  logic [pn2d_pkg::P16_W-1:0] p16x3_q, p16y3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      gaa3_q  <= pn2d_pkg::grad(h_aa, gx0, gy0);
      gba3_q  <= pn2d_pkg::grad(h_ba, gx1, gy0);
      gab3_q  <= pn2d_pkg::grad(h_ab, gx0, gy1);
      gbb3_q  <= pn2d_pkg::grad(h_bb, gx1, gy1);
      c24x3_q <= c24x_s[24 +: pn2d_pkg::C24_W];
      c24y3_q <= c24y_s[24 +: pn2d_pkg::C24_W];
      p16x3_q <= p16x2_q;
      p16y3_q <= p16y2_q;
    end
  end

  // ---------------- stage 4: fade product ----------------
  logic signed [pn2d_pkg::G_W-1:0] gaa4_q, gab4_q, gba4_q, gbb4_q;
  logic [pn2d_pkg::UR_W-1:0] urx4_q, ury4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      urx4_q <= pn2d_pkg::UR_W'(c24x3_q) * pn2d_pkg::UR_W'(p16x3_q);
      ury4_q <= pn2d_pkg::UR_W'(c24y3_q) * pn2d_pkg::UR_W'(p16y3_q);
      gaa4_q <= gaa3_q;
      gab4_q <= gab3_q;
      gba4_q <= gba3_q;
      gbb4_q <= gbb3_q;
    end
  end

  // ---------------- stage 5: fade rounding and clamp ----------------
  function automatic logic [pn2d_pkg::T_W-1:0] fade_of(input logic [pn2d_pkg::UR_W-1:0] ur);
    logic [pn2d_pkg::UR_W:0] s;
    logic [pn2d_pkg::UR_W-24:0] r;
    s = (pn2d_pkg::UR_W+1)'(ur) + (pn2d_pkg::UR_W+1)'(1 << 23);
    r = s[pn2d_pkg::UR_W:24];
    return (r > (pn2d_pkg::UR_W-23)'(pn2d_pkg::ONE_Q16)) ? pn2d_pkg::ONE_Q16
                                                         : pn2d_pkg::T_W'(r);
  endfunction

  logic signed [pn2d_pkg::G_W-1:0] gaa5_q, gab5_q, gba5_q, gbb5_q;
  logic [pn2d_pkg::T_W-1:0] u5_q, v5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      u5_q   <= fade_of(urx4_q);
      v5_q   <= fade_of(ury4_q);
      gaa5_q <= gaa4_q;
      gab5_q <= gab4_q;
      gba5_q <= gba4_q;
      gbb5_q <= gbb4_q;
    end
  end

  // ---------------- stage 6: x blend products ----------------
  logic signed [pn2d_pkg::DF_W-1:0] dfa, dfb;
  logic signed [pn2d_pkg::PX_W-1:0] u_s;
  assign dfa = pn2d_pkg::DF_W'(gba5_q) - pn2d_pkg::DF_W'(gaa5_q);
  assign dfb = pn2d_pkg::DF_W'(gbb5_q) - pn2d_pkg::DF_W'(gab5_q);
  assign u_s = $signed(pn2d_pkg::PX_W'(u5_q));

  logic signed [pn2d_pkg::PX_W-1:0] px1_6_q, px2_6_q;
  logic signed [pn2d_pkg::G_W-1:0] gaa6_q, gab6_q;
  logic [pn2d_pkg::T_W-1:0] v6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      px1_6_q <= u_s * pn2d_pkg::PX_W'(dfa);
      px2_6_q <= u_s * pn2d_pkg::PX_W'(dfb);
      gaa6_q  <= gaa5_q;
      gab6_q  <= gab5_q;
      v6_q    <= v5_q;
    end
  end

  // ---------------- stage 7: x blend rounding ----------------
  logic signed [pn2d_pkg::PX_W:0] rx1, rx2;
  assign rx1 = (pn2d_pkg::PX_W+1)'(px1_6_q) + (pn2d_pkg::PX_W+1)'(32768);
  assign rx2 = (pn2d_pkg::PX_W+1)'(px2_6_q) + (pn2d_pkg::PX_W+1)'(32768);

  logic signed [pn2d_pkg::X_W-1:0] x1_7_q, x2_7_q;
  logic [pn2d_pkg::T_W-1:0] v7_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      x1_7_q <= pn2d_pkg::X_W'(gaa6_q) + pn2d_pkg::X_W'(rx1 >>> 16);
      x2_7_q <= pn2d_pkg::X_W'(gab6_q) + pn2d_pkg::X_W'(rx2 >>> 16);
      v7_q   <= v6_q;
    end
  end

  // ---------------- stage 8: y blend product ----------------
  logic signed [pn2d_pkg::DX_W-1:0] dx;
  assign dx = pn2d_pkg::DX_W'(x2_7_q) - pn2d_pkg::DX_W'(x1_7_q);

  logic signed [pn2d_pkg::PY_W-1:0] py8_q;
  logic signed [pn2d_pkg::X_W-1:0] x1_8_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      py8_q  <= $signed(pn2d_pkg::PY_W'(v7_q)) * pn2d_pkg::PY_W'(dx);
      x1_8_q <= x1_7_q;
    end
  end

  // ---------------- stage 9: final rounding, offset, saturation ----------------
  logic signed [pn2d_pkg::PY_W:0] ry;
  logic signed [pn2d_pkg::Y_W-1:0] y1;
  logic signed [pn2d_pkg::Y_W+1:0] ys;
  logic signed [pn2d_pkg::Y_W+1:0] yr;
  logic signed [pn2d_pkg::NOISE_W-1:0] noise_d;
  assign ry = (pn2d_pkg::PY_W+1)'(py8_q) + (pn2d_pkg::PY_W+1)'(32768);
  assign y1 = pn2d_pkg::Y_W'(x1_8_q) + pn2d_pkg::Y_W'(ry >>> 16);
  assign ys = (pn2d_pkg::Y_W+2)'(y1) + (pn2d_pkg::Y_W+2)'(65537);
  assign yr = ys >>> 1;

  always_comb begin
    if (yr > (pn2d_pkg::Y_W+2)'(pn2d_pkg::NOISE_MAX)) begin
      noise_d = pn2d_pkg::NOISE_MAX;
    end else if (yr < (pn2d_pkg::Y_W+2)'(pn2d_pkg::NOISE_MIN)) begin
      noise_d = pn2d_pkg::NOISE_MIN;
    end else begin
      noise_d = pn2d_pkg::NOISE_W'(yr);
    end
  end

  logic signed [pn2d_pkg::NOISE_W-1:0] noise_q;
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      noise_q <= noise_d;
    end
  end

  assign out_o.valid       = v_q[NSTG-1];
  assign out_o.noise_value = noise_q;

endmodule

// File: rtl/pn2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn2d_checker: port-level checks of the noise block
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module pn2d_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [pn2d_pkg::NOISE_W-1:0] noise_value_i
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(noise_value_i))
    else $error("result changed while stalled");

  // With an empty output register nothing in the pipeline can be blocked.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A result only leaves after a transfer.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result dropped without transfer");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

  // Right after reset, a result that is shown must not hold off a waiting input.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i || !in_valid_i || in_ready_i)
    else $error("result right after reset");

endmodule

bind perlin_noise_2d pn2d_checker u_pn2d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .noise_value_i (out_o.noise_value)
);
